// ----- src/dts_pkg.sv -----
// Shared types, constants and helpers for the delimiter token splitter.
`default_nettype none
package dts_pkg;

    localparam int MAX_DELIM  = 8;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int FILL_W     = 3;
    localparam int DELIM_W    = MAX_DELIM * BYTE_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = DELIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 4'd1;

    localparam logic [LEN_W-1:0]   RST_DELIM_LEN   = 4'd1;
    localparam logic [DELIM_W-1:0] RST_DELIM_BYTES = 64'd44;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One queue entry: the token bytes one input beat produces.
    typedef struct packed {
        logic [MAX_DELIM-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                 count;
        logic                             first_new;
        logic                             str_end;
    } dts_job_t;

    // Delimiter length clamped to 1..MAX_DELIM.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] l;
        begin
            l = raw;
            if (raw == '0)
            begin
                l = LEN_W'(1);
            end
            else if (raw > LEN_W'(MAX_DELIM))
            begin
                l = LEN_W'(MAX_DELIM);
            end
            return l;
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/delimiter_token_splitter_core.sv -----
// Top level of the delimiter token splitter: front end, job queue and emitter.
// Each result beat is held in the job queue and then in the output register.
// Throughput: one input beat per cycle while in_stall is low; an input beat with
// k results holds the emitter for k output beats, so the end-of-string flush
// emits up to eight bytes. Reset empties the window fill (not its bytes), clears
// the token state and the queue, and sets the delimiter to one byte, a comma.
`default_nettype none
module delimiter_token_splitter_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [dts_pkg::BYTE_W-1:0]      data_byte,
    input  wire logic                            is_last,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [dts_pkg::BYTE_W-1:0]           out_byte,
    output logic                                 new_token,
    output logic                                 run_last,
    output logic                                 string_done
);

    logic               push_valid;
    logic               push_stall;
    dts_pkg::dts_job_t  push_job;
    logic               head_valid;
    logic               pop;
    dts_pkg::dts_job_t  head_job;

    dts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_job   (push_job)
    );

    dts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_job   (push_job),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    dts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .new_token   (new_token),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule
`default_nettype wire

// ----- src/dts_front.sv -----
// Front end: configuration registers, match window and job building.
`default_nettype none
module dts_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [dts_pkg::BYTE_W-1:0]      data_byte,
    input  wire logic                            is_last,
    output logic                                 push_valid,
    input  wire logic                            push_stall,
    output dts_pkg::dts_job_t                    push_job
);

    logic [dts_pkg::LEN_W-1:0]                          delim_len_reg;
    logic [dts_pkg::DELIM_W-1:0]                        delim_bytes_reg;
    logic [dts_pkg::MAX_DELIM-1:0][dts_pkg::BYTE_W-1:0] win_reg;
    logic [dts_pkg::MAX_DELIM-1:0][dts_pkg::BYTE_W-1:0] win_next;
    logic [dts_pkg::FILL_W-1:0]                         fill_reg;
    logic [dts_pkg::FILL_W-1:0]                         fill_next;
    logic                                               tok_reg;
    logic                                               tok_next;

    logic [dts_pkg::MAX_DELIM-1:0][dts_pkg::BYTE_W-1:0] w;
    logic [dts_pkg::MAX_DELIM-1:0][dts_pkg::BYTE_W-1:0] d;
    logic [dts_pkg::LEN_W-1:0]                          len;
    logic [dts_pkg::LEN_W-1:0]                          len_m1;
    logic [dts_pkg::LEN_W-1:0]                          fill1;
    logic                                               full;
    logic                                               match;
    logic                                               accept;
    logic                                               cfg_hit;

    assign in_stall = push_stall;
    assign accept   = in_valid && !push_stall;
    assign len      = dts_pkg::eff_len(delim_len_reg);
    assign len_m1   = len - dts_pkg::LEN_W'(1);
    assign fill1    = {1'b0, fill_reg} + dts_pkg::LEN_W'(1);
    assign full     = (fill1 == len);
    assign d        = delim_bytes_reg;
    assign cfg_hit  = cfg_we && ((cfg_index == dts_pkg::REG_DELIM_LEN) ||
                                 (cfg_index == dts_pkg::REG_DELIM_BYTES));

    always_comb
    begin
        w = win_reg;
        w[fill_reg] = data_byte;
    end

    // Entries past the delimiter length always compare equal.
    always_comb
    begin
        match = 1'b1;
        for (int k = 0; k < dts_pkg::MAX_DELIM; k++)
        begin
            if ((dts_pkg::LEN_W'(k) < len) && (w[k] != d[k]))
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        push_job.bytes     = w;
        push_job.first_new = !tok_reg;
        push_job.str_end   = is_last;
        if (is_last)
        begin
            push_job.count = (full && match) ? '0 : fill1;
        end
        else
        begin
            push_job.count = (full && !match) ? dts_pkg::LEN_W'(1) : '0;
        end
    end

    assign push_valid = accept && (push_job.count != '0);

    always_comb
    begin
        win_next  = w;
        fill_next = fill_reg;
        tok_next  = tok_reg;
        if (is_last)
        begin
            fill_next = '0;
            tok_next  = 1'b0;
        end
        else if (full && match)
        begin
            fill_next = '0;
            tok_next  = 1'b0;
        end
        else if (full)
        begin
            for (int k = 0; k < dts_pkg::MAX_DELIM - 1; k++)
            begin
                win_next[k] = w[k + 1];
            end
            fill_next = len_m1[dts_pkg::FILL_W-1:0];
            tok_next  = 1'b1;
        end
        else
        begin
            fill_next = fill1[dts_pkg::FILL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_len_reg   <= dts_pkg::RST_DELIM_LEN;
            delim_bytes_reg <= dts_pkg::RST_DELIM_BYTES;
            fill_reg        <= '0;
            tok_reg         <= 1'b0;
        end
        else if (cfg_hit)
        begin
            if (cfg_index == dts_pkg::REG_DELIM_LEN)
            begin
                delim_len_reg <= cfg_data[dts_pkg::LEN_W-1:0];
            end
            else
            begin
                delim_bytes_reg <= cfg_data;
            end
            fill_reg <= '0;
            tok_reg  <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cfg_hit)
        begin
            win_reg <= win_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/dts_queue.sv -----
// Short job queue between the front end and the emitter.
`default_nettype none
module dts_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_stall,
    input  wire dts_pkg::dts_job_t push_job,
    output logic                   head_valid,
    input  wire logic              pop,
    output dts_pkg::dts_job_t      head_job
);

    dts_pkg::dts_job_t               entry_reg [dts_pkg::QUEUE_DEPTH];
    logic [dts_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [dts_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [dts_pkg::QCNT_W-1:0]      cnt_reg;
    logic [dts_pkg::QCNT_W-1:0]      cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_stall = (cnt_reg == dts_pkg::QCNT_W'(dts_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + dts_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - dts_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + dts_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + dts_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ----- src/dts_back.sv -----
// Emitter: walks each queued job and drives one output beat per byte.
`default_nettype none
module dts_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        head_valid,
    input  wire dts_pkg::dts_job_t           head_job,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [dts_pkg::BYTE_W-1:0]       out_byte,
    output logic                             new_token,
    output logic                             run_last,
    output logic                             string_done
);

    logic [dts_pkg::FILL_W-1:0]  idx_reg;
    logic [dts_pkg::FILL_W-1:0]  idx_next;
    logic                        out_valid_reg;
    logic [dts_pkg::BYTE_W-1:0]  byte_reg;
    logic                        new_reg;
    logic                        run_last_reg;
    logic                        done_reg;
    logic                        load;
    logic                        job_end;

    assign load    = head_valid && (!out_valid_reg || !out_stall);
    assign job_end = ({1'b0, idx_reg} == (head_job.count - dts_pkg::LEN_W'(1)));
    assign pop     = load && job_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = job_end ? '0 : idx_reg + dts_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= head_job.bytes[idx_reg];
            new_reg      <= head_job.first_new && (idx_reg == '0);
            run_last_reg <= job_end;
            done_reg     <= job_end && head_job.str_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign new_token   = new_reg;
    assign run_last    = run_last_reg;
    assign string_done = done_reg;

endmodule
`default_nettype wire
